### hw/rtl/rtcu_pkg.sv
// rtcu_pkg: types and constants of the ray/triangle closest-hit unit.
// No dependencies; used by every module of the block.
`default_nettype none

package rtcu_pkg;

  localparam int CW            = 32;         // coordinate width, signed fixed point
  localparam int FRAC_BITS_DEF = 16;         // default fraction bits
  localparam int DW            = CW + 1;     // width of a vertex difference
  localparam int CFG_AW        = 3;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [CFG_AW-1:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_DIR_X    = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_DIR_Y    = 3'd4;
  localparam logic [CFG_AW-1:0] CFG_DIR_Z    = 3'd5;
  localparam logic [CFG_AW-1:0] CFG_MAX_LEN  = 3'd6;

  typedef struct packed {
    logic                 new_ray;
    logic signed [CW-1:0] v0_x, v0_y, v0_z;
    logic signed [CW-1:0] v1_x, v1_y, v1_z;
    logic signed [CW-1:0] v2_x, v2_y, v2_z;
  } in_item_t;

  typedef struct packed {
    logic                 is_hit;
    logic                 is_closer;
    logic signed [CW-1:0] distance;
    logic signed [CW-1:0] weight_a;
    logic signed [CW-1:0] weight_b;
    logic signed [CW-1:0] weight_c;
    logic                 any_hit;
  } out_item_t;

  typedef struct packed {
    logic signed [CW-1:0] origin_x, origin_y, origin_z;
    logic signed [CW-1:0] dir_x, dir_y, dir_z;
    logic [CW-2:0]        max_length;
  } ray_t;

  // p = v0 - v1, q = v0 - v2, s = v0 - origin
  typedef struct packed {
    logic               new_ray;
    logic [2:0][DW-1:0] p;
    logic [2:0][DW-1:0] q;
    logic [2:0][DW-1:0] s;
  } job_t;

endpackage

`default_nettype wire

### hw/rtl/rtcu_front.sv
// rtcu_front: takes triangle items, forms edge and origin differences,
// and queues them for the back end. Depends on rtcu_pkg.
`default_nettype none

module rtcu_front import rtcu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_item,
  input  ray_t     ray,
  output logic     job_valid,
  input  logic     job_pop,
  output job_t     job
);

  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  job_t           q_mem_r [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   count_r, count_nxt;
  logic           push, pop;
  job_t           new_job;

  function automatic logic [DW-1:0] sdiff(input logic [CW-1:0] a, input logic [CW-1:0] b);
    sdiff = {a[CW-1], a} - {b[CW-1], b};
  endfunction

  always_comb begin
    new_job.new_ray = in_item.new_ray;
    new_job.p[0] = sdiff(in_item.v0_x, in_item.v1_x);
    new_job.p[1] = sdiff(in_item.v0_y, in_item.v1_y);
    new_job.p[2] = sdiff(in_item.v0_z, in_item.v1_z);
    new_job.q[0] = sdiff(in_item.v0_x, in_item.v2_x);
    new_job.q[1] = sdiff(in_item.v0_y, in_item.v2_y);
    new_job.q[2] = sdiff(in_item.v0_z, in_item.v2_z);
    new_job.s[0] = sdiff(in_item.v0_x, ray.origin_x);
    new_job.s[1] = sdiff(in_item.v0_y, ray.origin_y);
    new_job.s[2] = sdiff(in_item.v0_z, ray.origin_z);
  end

  assign in_stall  = (count_r == (QAW+1)'(QUEUE_DEPTH));
  assign job_valid = (count_r != '0);
  assign job       = q_mem_r[rd_ptr_r];
  assign push      = in_valid && !in_stall;
  assign pop       = job_pop && job_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= new_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rtcu_div.sv
// rtcu_div: bit-serial signed divider, (num << FRAC_BITS) / den truncated
// toward zero and saturated to CW bits. Depends on rtcu_pkg.
`default_nettype none

module rtcu_div import rtcu_pkg::*; #(
  parameter int NW        = 3 * DW + 3,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [NW-1:0] num,
  input  logic signed [NW-1:0] den,
  output logic                 busy,
  output logic signed [CW-1:0] quo
);

  localparam int QB  = CW + 1;
  localparam int NNW = NW + FRAC_BITS;
  localparam int CTW = $clog2(QB + 1);

  localparam logic [1:0] D_IDLE  = 2'd0;
  localparam logic [1:0] D_CHECK = 2'd1;
  localparam logic [1:0] D_RUN   = 2'd2;
  localparam logic [1:0] D_SAT   = 2'd3;

  localparam logic [QB-1:0] HALF = QB'(1) << (CW - 1);
  localparam logic [QB-1:0] MAXQ = HALF - 1'b1;
  localparam logic [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

  logic [1:0]     st_r, st_nxt;
  logic           neg_r, ovf_r;
  logic [NNW-1:0] nmag_r, nshift;
  logic [NW-1:0]  dmag_r, nabs, dabs;
  logic [NW:0]    rem_r, rs, rsub;
  logic [QB-1:0]  qmag_r, qneg;
  logic [CTW-1:0] cnt_r;
  logic [CW-1:0]  quo_r;
  logic           ge;

  assign nabs   = num[NW-1] ? NW'(-num) : NW'(num);
  assign dabs   = den[NW-1] ? NW'(-den) : NW'(den);
  assign nshift = nmag_r >> QB;
  assign rs     = {rem_r[NW-1:0], nmag_r[QB-1]};
  assign ge     = (rs >= {1'b0, dmag_r});
  assign rsub   = rs - {1'b0, dmag_r};
  assign qneg   = QB'(0) - qmag_r;
  assign busy   = (st_r != D_IDLE);
  assign quo    = quo_r;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      D_IDLE:  if (start) st_nxt = D_CHECK;
      D_CHECK: st_nxt = (nshift >= NNW'(dmag_r)) ? D_SAT : D_RUN;
      D_RUN:   if (cnt_r == CTW'(1)) st_nxt = D_SAT;
      D_SAT:   st_nxt = D_IDLE;
      default: st_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (st_r)
      D_IDLE: begin
        if (start) begin
          neg_r  <= num[NW-1] ^ den[NW-1];
          nmag_r <= {nabs, {FRAC_BITS{1'b0}}};
          dmag_r <= dabs;
          qmag_r <= '0;
        end
      end
      D_CHECK: begin
        ovf_r <= (nshift >= NNW'(dmag_r));
        rem_r <= nshift[NW:0];
        cnt_r <= CTW'(QB);
      end
      D_RUN: begin
        rem_r  <= ge ? rsub : rs;
        qmag_r <= {qmag_r[QB-2:0], ge};
        nmag_r <= nmag_r << 1;
        cnt_r  <= cnt_r - 1'b1;
      end
      D_SAT: begin
        if (neg_r) begin
          quo_r <= (ovf_r || qmag_r > HALF) ? MINV : qneg[CW-1:0];
        end else begin
          quo_r <= (ovf_r || qmag_r > MAXQ) ? MAXV : qmag_r[CW-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= D_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rtcu_back.sv
// rtcu_back: multiply-accumulate sequencer for the Cramer determinants,
// three dividers, hit test, closest-hit state and result register.
// Depends on rtcu_pkg and rtcu_div.
`default_nettype none

module rtcu_back import rtcu_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      job_valid,
  output logic      job_pop,
  input  job_t      job,
  input  ray_t      ray,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int XW = 2 * DW + 1;   // cross product component
  localparam int MW = DW + 1;       // multiplier operand
  localparam int PW = 2 * MW;       // product
  localparam int NW = 3 * DW + 3;   // determinant

  localparam logic [2:0] B_IDLE   = 3'd0;
  localparam logic [2:0] B_MAC    = 3'd1;
  localparam logic [2:0] B_DRAIN  = 3'd2;
  localparam logic [2:0] B_DIV_GO = 3'd3;
  localparam logic [2:0] B_DIV    = 3'd4;
  localparam logic [2:0] B_POST   = 3'd5;
  localparam logic [2:0] B_OUT    = 3'd6;

  // accumulation groups: h = q x dir, k = p x s, then the four dot products
  localparam logic [2:0] G_H   = 3'd0;
  localparam logic [2:0] G_K   = 3'd1;
  localparam logic [2:0] G_DEN = 3'd2;
  localparam logic [2:0] G_NB  = 3'd3;
  localparam logic [2:0] G_NG  = 3'd4;
  localparam logic [2:0] G_NT  = 3'd5;

  localparam logic [CW-1:0]        MAXV = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0]        MINV = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW+1:0] ONE  = (CW+2)'(1) << FRAC_BITS;

  typedef struct packed {
    logic       vld;
    logic       first;
    logic       shift;
    logic       neg;
    logic       store;
    logic [2:0] grp;
    logic [1:0] comp;
  } mac_ctl_t;

  function automatic logic [1:0] nxt3(input logic [1:0] j);
    nxt3 = (j == 2'd2) ? 2'd0 : j + 2'd1;
  endfunction

  function automatic logic nonpos(input logic [NW+1:0] v);
    nonpos = v[NW+1] || (v == '0);
  endfunction

  logic [2:0]         st_r, st_nxt;
  logic               new_ray_r;
  logic [2:0][DW-1:0] p_r, q_r, s_r, rv;
  logic [2:0][XW-1:0] h_r, k_r;
  logic [2:0]         grp_r;
  logic [1:0]         comp_r;
  logic               half_r;
  mac_ctl_t           ctl, ctl_r;
  logic signed [MW-1:0] a_sel, b_sel;
  logic signed [PW-1:0] prod_r;
  logic signed [NW-1:0] acc_r, acc_base, term, acc_nxt;
  logic signed [NW-1:0] den_r, nb_r, ng_r, nt_r;
  logic [NW+1:0]      na_r;
  logic [2:0][DW-1:0] uv, wv, av;
  logic [2:0][XW-1:0] xv;
  logic [1:0]         j1, j2;
  logic               last_issue;

  logic                 div_go, b_busy, c_busy, t_busy;
  logic signed [CW-1:0] qb, qc, qt;
  logic signed [CW+1:0] asum;

  logic                 res_hit_r;
  logic signed [CW-1:0] res_t_r, res_a_r, res_b_r, res_c_r;
  logic signed [CW-1:0] closest_r, closest_eff;
  logic                 seen_r, seen_eff, closer, load_out;
  logic                 out_valid_r;
  out_item_t            out_item_r;

  assign rv[0] = {ray.dir_x[CW-1], ray.dir_x};
  assign rv[1] = {ray.dir_y[CW-1], ray.dir_y};
  assign rv[2] = {ray.dir_z[CW-1], ray.dir_z};
  assign j1 = nxt3(comp_r);
  assign j2 = nxt3(j1);
  assign last_issue = (grp_r == G_NT) && (comp_r == 2'd2) && half_r;

  // operand selection for the shared multiplier
  always_comb begin
    uv = (grp_r == G_H) ? q_r : p_r;
    wv = (grp_r == G_H) ? rv  : s_r;
    case (grp_r)
      G_DEN:   av = p_r;
      G_NB:    av = s_r;
      G_NG:    av = rv;
      default: av = q_r;
    endcase
    xv = (grp_r == G_DEN || grp_r == G_NB) ? h_r : k_r;
    ctl.vld  = (st_r == B_MAC);
    ctl.grp  = grp_r;
    ctl.comp = comp_r;
    if (grp_r == G_H || grp_r == G_K) begin
      a_sel = half_r ? {uv[j2][DW-1], uv[j2]} : {uv[j1][DW-1], uv[j1]};
      b_sel = half_r ? {wv[j1][DW-1], wv[j1]} : {wv[j2][DW-1], wv[j2]};
      ctl.first = !half_r;
      ctl.shift = 1'b0;
      ctl.neg   = half_r;
      ctl.store = half_r;
    end else begin
      a_sel = {av[comp_r][DW-1], av[comp_r]};
      b_sel = half_r ? xv[comp_r][XW-1:DW] : {1'b0, xv[comp_r][DW-1:0]};
      ctl.first = (comp_r == 2'd0) && !half_r;
      ctl.shift = half_r;
      ctl.neg   = (grp_r == G_NT);
      ctl.store = (comp_r == 2'd2) && half_r;
    end
  end

  // accumulate stage
  always_comb begin
    term     = {{(NW-PW){prod_r[PW-1]}}, prod_r};
    term     = ctl_r.shift ? (term <<< DW) : term;
    acc_base = ctl_r.first ? '0 : acc_r;
    acc_nxt  = ctl_r.neg ? acc_base - term : acc_base + term;
  end

  always_ff @(posedge clk) begin
    prod_r <= a_sel * b_sel;
    if (ctl_r.vld) begin
      acc_r <= acc_nxt;
      if (ctl_r.store) begin
        case (ctl_r.grp)
          G_H:     h_r[ctl_r.comp] <= acc_nxt[XW-1:0];
          G_K:     k_r[ctl_r.comp] <= acc_nxt[XW-1:0];
          G_DEN:   den_r <= acc_nxt;
          G_NB:    nb_r  <= acc_nxt;
          G_NG:    ng_r  <= acc_nxt;
          default: nt_r  <= acc_nxt;
        endcase
      end
    end
  end

  assign div_go = (st_r == B_DIV_GO);

  rtcu_div #(.NW(NW), .FRAC_BITS(FRAC_BITS)) u_div_b (
    .clk(clk), .rst_n(rst_n), .start(div_go), .num(nb_r), .den(den_r),
    .busy(b_busy), .quo(qb));
  rtcu_div #(.NW(NW), .FRAC_BITS(FRAC_BITS)) u_div_c (
    .clk(clk), .rst_n(rst_n), .start(div_go), .num(ng_r), .den(den_r),
    .busy(c_busy), .quo(qc));
  rtcu_div #(.NW(NW), .FRAC_BITS(FRAC_BITS)) u_div_t (
    .clk(clk), .rst_n(rst_n), .start(div_go), .num(nt_r), .den(den_r),
    .busy(t_busy), .quo(qt));

  assign asum = ONE - {{2{qb[CW-1]}}, qb} - {{2{qc[CW-1]}}, qc};

  assign closest_eff = new_ray_r ? MAXV : closest_r;
  assign seen_eff    = new_ray_r ? 1'b0 : seen_r;
  assign closer      = res_hit_r && (res_t_r < closest_eff);
  assign load_out    = (st_r == B_OUT) && (!out_valid_r || !out_stall);
  assign job_pop     = (st_r == B_IDLE) && job_valid;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      B_IDLE:   if (job_valid) st_nxt = B_MAC;
      B_MAC:    if (last_issue) st_nxt = B_DRAIN;
      B_DRAIN:  st_nxt = B_DIV_GO;
      B_DIV_GO: st_nxt = den_r[NW-1] ? B_DIV : B_OUT;
      B_DIV:    if (!b_busy && !c_busy && !t_busy) st_nxt = B_POST;
      B_POST:   st_nxt = B_OUT;
      B_OUT:    if (load_out) st_nxt = B_IDLE;
      default:  st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      new_ray_r <= job.new_ray;
      p_r <= job.p;
      q_r <= job.q;
      s_r <= job.s;
    end
    if (st_r == B_DIV_GO) begin
      na_r    <= {{2{den_r[NW-1]}}, den_r} - {{2{nb_r[NW-1]}}, nb_r}
                 - {{2{ng_r[NW-1]}}, ng_r};
      res_hit_r <= 1'b0;
      res_t_r   <= '0;
      res_a_r   <= '0;
      res_b_r   <= '0;
      res_c_r   <= '0;
    end
    if (st_r == B_POST) begin
      res_t_r <= qt;
      res_b_r <= qb;
      res_c_r <= qc;
      if (asum > $signed({{2{MAXV[CW-1]}}, MAXV})) begin
        res_a_r <= MAXV;
      end else if (asum < $signed({{2{MINV[CW-1]}}, MINV})) begin
        res_a_r <= MINV;
      end else begin
        res_a_r <= asum[CW-1:0];
      end
      res_hit_r <= nonpos(na_r) && nonpos({{2{nb_r[NW-1]}}, nb_r})
                   && nonpos({{2{ng_r[NW-1]}}, ng_r})
                   && (qt <= $signed({1'b0, ray.max_length}));
    end
    if (load_out) begin
      out_item_r.is_hit    <= res_hit_r;
      out_item_r.is_closer <= closer;
      out_item_r.distance  <= res_t_r;
      out_item_r.weight_a  <= res_a_r;
      out_item_r.weight_b  <= res_b_r;
      out_item_r.weight_c  <= res_c_r;
      out_item_r.any_hit   <= seen_eff || res_hit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_IDLE;
      ctl_r       <= '0;
      grp_r       <= G_H;
      comp_r      <= '0;
      half_r      <= 1'b0;
      closest_r   <= MAXV;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      ctl_r <= ctl;
      if (job_pop) begin
        grp_r  <= G_H;
        comp_r <= '0;
        half_r <= 1'b0;
      end else if (st_r == B_MAC) begin
        half_r <= !half_r;
        if (half_r) begin
          if (comp_r == 2'd2) begin
            comp_r <= '0;
            grp_r  <= grp_r + 3'd1;
          end else begin
            comp_r <= comp_r + 2'd1;
          end
        end
      end
      if (load_out) begin
        closest_r   <= closer ? res_t_r : closest_eff;
        seen_r      <= seen_eff || res_hit_r;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

### hw/rtl/ray_triangle_closest_hit_unit.sv
// ray_triangle_closest_hit_unit: top level, ray configuration registers,
// front end with item queue and back end. Depends on rtcu_pkg, rtcu_front, rtcu_back.
//
//   port group   dir  handshake          payload
//   in_*         in   in_valid/in_stall  in_item_t   (one triangle)
//   out_*        out  out_valid/out_stall out_item_t (one result per triangle)
//   cfg_*        in   cfg_we             cfg_index, cfg_data
//
// A front-facing triangle runs 36 products through the one multiply-accumulate unit,
// then waits for the three bit-serial dividers; a culled or degenerate triangle
// does not wait for the dividers.
// Synchronous active-low reset; closest distance and hit flag reset, no clearing pass.
// A two-item queue lets the front take items while the back end works or the
// result register is stalled.
`default_nettype none

module ray_triangle_closest_hit_unit import rtcu_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_item,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [CW-1:0]     cfg_data
);

  ray_t ray_r;
  logic job_valid, job_pop;
  job_t job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ray_r.origin_x   <= '0;
      ray_r.origin_y   <= '0;
      ray_r.origin_z   <= '0;
      ray_r.dir_x      <= '0;
      ray_r.dir_y      <= '0;
      ray_r.dir_z      <= CW'(1) << FRAC_BITS;
      ray_r.max_length <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ORIGIN_X: ray_r.origin_x   <= cfg_data;
        CFG_ORIGIN_Y: ray_r.origin_y   <= cfg_data;
        CFG_ORIGIN_Z: ray_r.origin_z   <= cfg_data;
        CFG_DIR_X:    ray_r.dir_x      <= cfg_data;
        CFG_DIR_Y:    ray_r.dir_y      <= cfg_data;
        CFG_DIR_Z:    ray_r.dir_z      <= cfg_data;
        CFG_MAX_LEN:  ray_r.max_length <= cfg_data[CW-2:0];
        default: ;
      endcase
    end
  end

  rtcu_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .ray(ray_r),
    .job_valid(job_valid), .job_pop(job_pop), .job(job)
  );

  rtcu_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .job_valid(job_valid), .job_pop(job_pop), .job(job),
    .ray(ray_r),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  a_closer_is_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.is_closer |-> out_item.is_hit)
    else $error("closer result without hit");

  a_hit_sets_any: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.is_hit |-> out_item.any_hit)
    else $error("hit not reflected in any_hit");

  a_hit_weights: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.is_hit |->
      !out_item.weight_a[CW-1] && !out_item.weight_b[CW-1] && !out_item.weight_c[CW-1])
    else $error("negative barycentric on hit");

endmodule

`default_nettype wire
